[sv/single_source_shortest_path_assert.svh]
// Assertion macros for the shortest path block.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ssp_pkg.sv]
// Shared constants, token type and codes for the shortest path block.
// No dependencies.
package ssp_pkg;
  localparam int MAX_NODES  = 64;
  localparam int MAX_EDGES  = 256;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int NCNT_W     = $clog2(MAX_NODES + 1);
  localparam int EADDR_W    = $clog2(MAX_EDGES);
  localparam int ECNT_W     = $clog2(MAX_EDGES + 1);
  localparam int WEIGHT_W   = 16;
  localparam int DIST_W     = 32;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [DIST_W-1:0] DIST_INF = '1;
  localparam logic [DIST_W-1:0] DIST_TOP = {{(DIST_W-1){1'b1}}, 1'b0};

  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_SOURCE_NODE = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INIT,
    OP_SCAN,
    OP_VISIT,
    OP_RELAX
  } op_t;

  // Token moving down the cell chain, one cell per cycle.
  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] idx_a;
    logic              a_ok;
    logic [NODE_W-1:0] idx_b;
    logic              b_ok;
    logic [DIST_W-1:0] cost;
  } token_t;
endpackage

[sv/ssp_edge_if.sv]
// Edge input channel: valid/ready handshake plus one edge.
// Depends on ssp_pkg.
interface ssp_edge_if;
  logic                          valid;
  logic                          ready;
  logic [ssp_pkg::NODE_W-1:0]    end_one;
  logic [ssp_pkg::NODE_W-1:0]    end_two;
  logic [ssp_pkg::WEIGHT_W-1:0]  weight;
  logic                          last_edge;

  modport source (output valid, end_one, end_two, weight, last_edge, input ready);
  modport sink (input valid, end_one, end_two, weight, last_edge, output ready);
endinterface

[sv/ssp_result_if.sv]
// Result output channel: valid/ready handshake plus one node distance.
// Depends on ssp_pkg.
interface ssp_result_if;
  logic                        valid;
  logic                        ready;
  logic [ssp_pkg::NODE_W-1:0]  node;
  logic [ssp_pkg::DIST_W-1:0]  distance;
  logic                        reachable;
  logic                        last;

  modport source (output valid, node, distance, reachable, last, input ready);
  modport sink (input valid, node, distance, reachable, last, output ready);
endinterface

[sv/single_source_shortest_path.sv]
// Shortest path search: edges load one transfer per cycle while idle.
// After the last edge, an init step, then n rounds run through a 64-cell chain;
// in each round the scan token ripples the chain, then the E stored edges
// stream from the edge memory (none when the picked node is unreachable or no
// edges are stored). After the last round the chain drains, then n results leave at
// one per cycle while the receiver holds ready. Reset is synchronous; edges loaded drops to zero.
module single_source_shortest_path (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssp_pkg::APB_AW-1:0]  paddr,
  input  logic [ssp_pkg::APB_DW-1:0]  pwdata,
  output logic [ssp_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  ssp_edge_if.sink                    edge_in,
  ssp_result_if.source                result_out
);
  import ssp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_SCAN, ST_WAIT, ST_VISIT, ST_EDGE, ST_DRAIN, ST_OUT
  } state_t;

  state_t              state;
  logic [NCNT_W-1:0]   node_count;
  logic [NODE_W-1:0]   source_node;
  logic [NCNT_W-1:0]   n_eff;
  logic                src_ok;
  logic [ECNT_W-1:0]   edges_loaded;
  logic [ECNT_W-1:0]   e_addr;
  logic [NCNT_W-1:0]   round;
  logic [NCNT_W-1:0]   wait_cnt;
  logic [NCNT_W-1:0]   out_cnt;
  logic [NODE_W-1:0]   best;
  logic [DIST_W-1:0]   bestd;

  logic [NODE_W-1:0]   mem_a [MAX_EDGES];
  logic [NODE_W-1:0]   mem_b [MAX_EDGES];
  logic [WEIGHT_W-1:0] mem_w [MAX_EDGES];
  logic [NODE_W-1:0]   rd_a;
  logic [NODE_W-1:0]   rd_b;
  logic [WEIGHT_W-1:0] rd_w;
  logic                rd_valid;

  token_t              tok   [MAX_NODES+1];
  logic [DIST_W-1:0]   cdist [MAX_NODES+1];
  token_t              inject;
  logic                shift_en;
  logic                in_xfer;
  logic                cfg_wr;
  logic [NCNT_W-1:0]   cnt_clip;
  logic [DIST_W:0]     sum;
  logic                in_range;
  logic [NCNT_W-1:0]   round_inc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (paddr[2] == REG_NODE_COUNT) ? APB_DW'(node_count) : APB_DW'(source_node);
  assign in_xfer = edge_in.valid && edge_in.ready;
  assign edge_in.ready = (state == ST_IDLE);

  always_comb begin
    if (node_count == '0) cnt_clip = NCNT_W'(1);
    else if (node_count > NCNT_W'(MAX_NODES)) cnt_clip = NCNT_W'(MAX_NODES);
    else cnt_clip = node_count;
  end

  // Head of the chain: build the token entering cell zero.
  assign sum      = {1'b0, bestd} + (DIST_W+1)'(rd_w);
  assign in_range = ({1'b0, rd_a} < n_eff) && ({1'b0, rd_b} < n_eff);
  always_comb begin
    inject       = '0;
    inject.op    = OP_NOP;
    if (rd_valid) begin
      inject.op    = OP_RELAX;
      inject.idx_a = rd_b;
      inject.a_ok  = in_range && (rd_a == best);
      inject.idx_b = rd_a;
      inject.b_ok  = in_range && (rd_b == best);
      inject.cost  = (sum > {1'b0, DIST_TOP}) ? DIST_TOP : sum[DIST_W-1:0];
    end else begin
      case (state)
        ST_INIT: begin
          inject.op    = OP_INIT;
          inject.idx_a = source_node;
          inject.a_ok  = src_ok;
        end
        ST_SCAN: begin
          inject.op   = OP_SCAN;
          inject.cost = DIST_INF;
        end
        ST_VISIT: begin
          inject.op    = OP_VISIT;
          inject.idx_a = best;
        end
        default: inject.op = OP_NOP;
      endcase
    end
  end

  assign tok[0]           = inject;
  assign cdist[MAX_NODES] = DIST_INF;
  assign shift_en = (state == ST_OUT) && (out_cnt != n_eff) &&
                    (!result_out.valid || result_out.ready);

  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    ssp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (NODE_W'(k)),
      .n_eff    (n_eff),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1]),
      .shift_en (shift_en),
      .dist_next(cdist[k+1]),
      .node_dist(cdist[k])
    );
  end

  // Edge memory: write on input transfer, registered read during a round.
  always_ff @(posedge clk) begin
    if (in_xfer && edges_loaded < ECNT_W'(MAX_EDGES)) begin
      mem_a[edges_loaded[EADDR_W-1:0]] <= edge_in.end_one;
      mem_b[edges_loaded[EADDR_W-1:0]] <= edge_in.end_two;
      mem_w[edges_loaded[EADDR_W-1:0]] <= edge_in.weight;
    end
    if (state == ST_EDGE) begin
      rd_a <= mem_a[e_addr[EADDR_W-1:0]];
      rd_b <= mem_b[e_addr[EADDR_W-1:0]];
      rd_w <= mem_w[e_addr[EADDR_W-1:0]];
    end
  end

  assign round_inc = round + NCNT_W'(1);

  // Raise on a new result, drop once the transfer is done.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (shift_en) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      node_count       <= NCNT_W'(MAX_NODES);
      source_node      <= '0;
      edges_loaded     <= '0;
      rd_valid         <= 1'b0;
    end else begin
      rd_valid <= (state == ST_EDGE);
      if (cfg_wr) begin
        if (paddr[2] == REG_NODE_COUNT) node_count <= pwdata[NCNT_W-1:0];
        else source_node <= pwdata[NODE_W-1:0];
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (edges_loaded < ECNT_W'(MAX_EDGES)) edges_loaded <= edges_loaded + ECNT_W'(1);
            if (edge_in.last_edge) begin
              n_eff  <= cnt_clip;
              src_ok <= {1'b0, source_node} < cnt_clip;
              round  <= '0;
              state  <= ST_INIT;
            end
          end
        end
        ST_INIT: state <= ST_SCAN;
        ST_SCAN: begin
          // Hold the scan until the last edge token has entered ahead of it.
          if (!rd_valid) state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (tok[MAX_NODES].op == OP_SCAN) begin
            best  <= tok[MAX_NODES].idx_a;
            bestd <= tok[MAX_NODES].cost;
            state <= ST_VISIT;
          end
        end
        ST_VISIT: begin
          e_addr <= '0;
          if (bestd != DIST_INF && edges_loaded != '0) begin
            state <= ST_EDGE;
          end else begin
            round    <= round_inc;
            wait_cnt <= '0;
            state    <= (round_inc == n_eff) ? ST_DRAIN : ST_SCAN;
          end
        end
        ST_EDGE: begin
          e_addr <= e_addr + ECNT_W'(1);
          if (e_addr + ECNT_W'(1) == edges_loaded) begin
            round    <= round_inc;
            wait_cnt <= '0;
            state    <= (round_inc == n_eff) ? ST_DRAIN : ST_SCAN;
          end
        end
        ST_DRAIN: begin
          wait_cnt <= wait_cnt + NCNT_W'(1);
          if (wait_cnt == NCNT_W'(MAX_NODES)) begin
            out_cnt <= '0;
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_cnt == n_eff) begin
            edges_loaded <= '0;
            state        <= ST_IDLE;
          end else if (shift_en) begin
            result_out.node      <= out_cnt[NODE_W-1:0];
            result_out.distance  <= cdist[0];
            result_out.reachable <= (cdist[0] != DIST_INF);
            result_out.last      <= (out_cnt + NCNT_W'(1) == n_eff);
            out_cnt              <= out_cnt + NCNT_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "single_source_shortest_path_assert.svh"

  `SSP_ASSERT_NOW(a_scan_exit, tok[MAX_NODES].op == OP_SCAN, state == ST_WAIT, "stray scan")
  `SSP_ASSERT_NEXT(a_out_hold, result_out.valid && !result_out.ready, result_out.valid, "result dropped")
  `SSP_ASSERT_NEXT(a_relax_gap, state == ST_EDGE, rd_valid, "edge read without relax token")
endmodule

[sv/ssp_cell.sv]
// One node cell of the chain: holds a node's distance and visited mark,
// acts on the token passing by and hands it on. Depends on ssp_pkg.
module ssp_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ssp_pkg::NODE_W-1:0] cell_idx,
  input  logic [ssp_pkg::NCNT_W-1:0] n_eff,
  input  ssp_pkg::token_t            tok_in,
  output ssp_pkg::token_t            tok_out,
  input  logic                       shift_en,
  input  logic [ssp_pkg::DIST_W-1:0] dist_next,
  output logic [ssp_pkg::DIST_W-1:0] node_dist
);
  import ssp_pkg::*;

  logic   visited;
  logic   in_use;
  logic   hit_a;
  logic   hit_b;
  token_t tok_next;

  assign in_use = {1'b0, cell_idx} < n_eff;
  assign hit_a  = tok_in.a_ok && (tok_in.idx_a == cell_idx);
  assign hit_b  = tok_in.b_ok && (tok_in.idx_b == cell_idx);

  always_comb begin
    tok_next = tok_in;
    // Ties go to the later cell, i.e. the higher index.
    if (tok_in.op == OP_SCAN && in_use && !visited && node_dist <= tok_in.cost) begin
      tok_next.cost  = node_dist;
      tok_next.idx_a = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited    <= 1'b0;
      tok_out.op <= OP_NOP;
    end else begin
      tok_out <= tok_next;
      case (tok_in.op)
        OP_INIT: begin
          visited   <= 1'b0;
          node_dist <= hit_a ? '0 : DIST_INF;
        end
        OP_VISIT: begin
          if (tok_in.idx_a == cell_idx) visited <= 1'b1;
        end
        OP_RELAX: begin
          if ((hit_a || hit_b) && tok_in.cost < node_dist) node_dist <= tok_in.cost;
        end
        default: begin
          if (shift_en) node_dist <= dist_next;
        end
      endcase
    end
  end
endmodule
